// File: src/smac_pkg.sv
// Shared constants, types and codes for the SIMD multiply-accumulate array.
`timescale 1ns / 1ps

package smac_pkg;

    localparam int CHANNEL_LANES = 4;
    localparam int WIDTH_LANES   = 4;
    localparam int OUTPUT_ROWS   = 64;
    localparam int LANE_SLOTS    = 4;

    localparam int ROW_W  = 6;
    localparam int DATA_W = 8;
    localparam int SUM_W  = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int DOT_W  = PROD_W + $clog2(CHANNEL_LANES) + 1;
    localparam int ROW_AW = (OUTPUT_ROWS > 1) ? $clog2(OUTPUT_ROWS) : 1;

    localparam int IN_FIELDS_W = ROW_W + LANE_SLOTS * DATA_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = LANE_SLOTS * SUM_W;

    localparam int TUSER_FUNC  = 0;
    localparam int TUSER_FIRST = 1;

    typedef enum logic {
        FUNC_LOAD    = 1'b0,
        FUNC_COMPUTE = 1'b1
    } t_func;

    typedef logic signed [DATA_W-1:0] t_byte;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DOT_W-1:0]  t_dot;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef t_byte [LANE_SLOTS-1:0]    t_lane_vec;
    typedef t_byte [CHANNEL_LANES-1:0] t_chan_vec;
    typedef t_chan_vec [WIDTH_LANES-1:0] t_col_set;
    typedef t_sum [WIDTH_LANES-1:0]    t_sum_row;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             first;
    } t_s1_info;

endpackage

// File: src/smac_data_file.sv
// Held data register file: one row per channel, one byte per width lane.
`timescale 1ns / 1ps

module smac_data_file (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [smac_pkg::ROW_W-1:0] i_wr_row,
    input  smac_pkg::t_lane_vec        i_lanes,
    output smac_pkg::t_col_set         o_cols
);
    import smac_pkg::*;

    t_byte [CHANNEL_LANES-1:0][WIDTH_LANES-1:0] r_file;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file <= '0;
        end else if (i_wr_en) begin
            for (int c = 0; c < CHANNEL_LANES; c++) begin
                if (i_wr_row == ROW_W'(c)) begin
                    for (int w = 0; w < WIDTH_LANES; w++) begin
                        r_file[c][w] <= i_lanes[w];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int w = 0; w < WIDTH_LANES; w++) begin
            for (int c = 0; c < CHANNEL_LANES; c++) begin
                o_cols[w][c] = r_file[c][w];
            end
        end
    end

endmodule

// File: src/smac_lane.sv
// One width lane: dot product of the weight row with the lane's channel column.
`timescale 1ns / 1ps

module smac_lane (
    input  logic                i_clk,
    input  logic                i_en,
    input  smac_pkg::t_chan_vec i_weights,
    input  smac_pkg::t_chan_vec i_data,
    output smac_pkg::t_dot      o_dot
);
    import smac_pkg::*;

    t_dot r_dot;
    t_dot n_dot;

    always_comb begin
        t_prod prod;
        n_dot = '0;
        for (int c = 0; c < CHANNEL_LANES; c++) begin
            prod  = $signed(i_data[c]) * $signed(i_weights[c]);
            n_dot = n_dot + DOT_W'(prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot <= n_dot;
        end
    end

    assign o_dot = r_dot;

endmodule

// File: src/simd_mac_array_with_accumulate_unit.sv
// Top level: input-stationary multiply-accumulate array with row accumulation.
// Usage:
//   Input stream s_axis: tuser selects the operation (bit 0 func, bit 1 first);
//   tdata carries row_index and four signed 8-bit lanes. A load (func 0)
//   writes one channel row of the data file and returns nothing. A compute
//   (func 1) applies a weight row to every width lane, adds the dot products
//   to the stored sums of output row k (or to zero when first is set), stores
//   the new sums and returns them on m_axis as four 32-bit values.
//   Throughput: one item per cycle, loads and computes mixed, unless m_axis stalls.
//   A compute transfer reaches m_axis_tvalid through the lane dot product
//   registers, loaded at the accepting edge, and then the output register,
//   which the merge adders load once the pipeline advances.
//   The partial sum memory has one registered read port and one write port;
//   a one-entry bypass of the last written row covers the read-after-write
//   gap so consecutive computes on the same row need no stall.
//   Reset clears the data file and all valid flags, not the partial sum
//   memory, so the user must start each row with a first=1 compute; the
//   block does not enforce this. When the receiver stalls, the output register
//   holds and s_axis_tready drops once it is full; no transfer is lost or repeated.
`timescale 1ns / 1ps

module simd_mac_array_with_accumulate_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // row_index[5:0], lane0[13:6], lane1[21:14], lane2[29:22], lane3[37:30], zero pad
    input  logic [smac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // func[0], first[1]
    input  logic [smac_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // sum0[31:0], sum1[63:32], sum2[95:64], sum3[127:96]
    output logic [smac_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import smac_pkg::*;

    t_func            w_func;
    logic             w_first;
    logic [ROW_W-1:0] w_row;
    t_lane_vec        w_lanes;
    logic             w_adv;
    logic             w_accept;
    logic             w_load_en;
    logic             w_comp_ok;
    logic             w_wr;
    logic             w_hit;
    t_col_set         w_cols;
    t_dot             w_dot [WIDTH_LANES];
    t_sum_row         n_sum;
    logic [OUT_TDATA_W-1:0] w_out_tdata;

    logic             r_s1_valid;
    t_s1_info         r_s1;
    t_sum_row         r_rd;
    t_sum_row         r_mem [OUTPUT_ROWS];
    logic             r_fw_valid;
    logic [ROW_W-1:0] r_fw_row;
    t_sum_row         r_fw_sum;
    logic             r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    assign w_func  = t_func'(s_axis_tuser[TUSER_FUNC]);
    assign w_first = s_axis_tuser[TUSER_FIRST];
    assign w_row   = s_axis_tdata[ROW_W-1:0];

    always_comb begin
        for (int i = 0; i < LANE_SLOTS; i++) begin
            w_lanes[i] = s_axis_tdata[ROW_W + i*DATA_W +: DATA_W];
        end
    end

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;
    assign w_load_en     = w_accept && (w_func == FUNC_LOAD);
    assign w_comp_ok     = w_accept && (w_func == FUNC_COMPUTE)
                           && ({1'b0, w_row} < (ROW_W + 1)'(OUTPUT_ROWS));

    smac_data_file u_data_file (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_load_en),
        .i_wr_row (w_row),
        .i_lanes  (w_lanes),
        .o_cols   (w_cols)
    );

    for (genvar w = 0; w < WIDTH_LANES; w++) begin : g_lane
        smac_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_adv),
            .i_weights (w_lanes[CHANNEL_LANES-1:0]),
            .i_data    (w_cols[w]),
            .o_dot     (w_dot[w])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_comp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1.row   <= w_row;
            r_s1.first <= w_first;
            r_rd       <= r_mem[w_row[ROW_AW-1:0]];
        end
        if (w_wr) begin
            r_mem[r_s1.row[ROW_AW-1:0]] <= n_sum;
        end
    end

    assign w_wr  = w_adv && r_s1_valid;
    assign w_hit = r_fw_valid && (r_fw_row == r_s1.row);

    always_comb begin
        t_sum base;
        for (int w = 0; w < WIDTH_LANES; w++) begin
            if (r_s1.first) begin
                base = '0;
            end else if (w_hit) begin
                base = r_fw_sum[w];
            end else begin
                base = r_rd[w];
            end
            n_sum[w] = base + SUM_W'(w_dot[w]);
        end
    end

    for (genvar s = 0; s < LANE_SLOTS; s++) begin : g_out
        if (s < WIDTH_LANES) begin : g_used
            assign w_out_tdata[s*SUM_W +: SUM_W] = n_sum[s];
        end else begin : g_unused
            assign w_out_tdata[s*SUM_W +: SUM_W] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr) begin
                r_fw_valid <= 1'b1;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_fw_row    <= r_s1.row;
            r_fw_sum    <= n_sum;
            r_out_tdata <= w_out_tdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule
